/* rtl/fbms_pkg.sv */
// ----------------------------------------------------------------------------
// fbms_pkg
// Shared types and codes for the batch max-select queue.
// ----------------------------------------------------------------------------
package fbms_pkg;

  localparam int TAG_W   = 16;
  localparam int SCORE_W = 16;
  localparam int BATCH_W = 7;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;

  // commands
  localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BEST = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TEAM = 2'd2;

  // result status
  localparam logic [STAT_W-1:0] ST_SEL  = 2'd0;
  localparam logic [STAT_W-1:0] ST_NONE = 2'd1;
  localparam logic [STAT_W-1:0] ST_ENQ  = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [SCORE_W-1:0] score;
  } entry_t;

  // sequencer -> compare unit
  typedef struct packed {
    logic valid;  // read data of a batch entry is present this cycle
    logic first;  // it is the first entry of the batch
  } cmp_ctl_t;

  // compare unit -> tail write
  typedef struct packed {
    logic   en;
    entry_t data;
  } push_t;

endpackage

/* rtl/fbms_req_if.sv */
// ----------------------------------------------------------------------------
// fbms_req_if
// Command channel: valid/ready with one command item.
// ----------------------------------------------------------------------------
interface fbms_req_if;
  logic                          valid;
  logic                          ready;
  logic [fbms_pkg::CMD_W-1:0]    cmd;
  logic [fbms_pkg::TAG_W-1:0]    entry_tag;
  logic [fbms_pkg::SCORE_W-1:0]  entry_score;
  logic [fbms_pkg::BATCH_W-1:0]  batch_len;

  modport source (output valid, cmd, entry_tag, entry_score, batch_len, input ready);
  modport sink   (input valid, cmd, entry_tag, entry_score, batch_len, output ready);
endinterface

/* rtl/fbms_rsp_if.sv */
// ----------------------------------------------------------------------------
// fbms_rsp_if
// Result channel: valid/ready with one result item.
// ----------------------------------------------------------------------------
interface fbms_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [fbms_pkg::TAG_W-1:0]    out_tag;
  logic [fbms_pkg::SCORE_W-1:0]  out_score;
  logic [fbms_pkg::STAT_W-1:0]   status;
  logic                          last;

  modport source (output valid, out_tag, out_score, status, last, input ready);
  modport sink   (input valid, out_tag, out_score, status, last, output ready);
endinterface

/* rtl/fbms_ram.sv */
// ----------------------------------------------------------------------------
// fbms_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fbms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/fbms_cmp.sv */
// ----------------------------------------------------------------------------
// fbms_cmp
// Running-max compare unit: keeps the current best of a batch and names the
// entry that goes back to the tail on each compare.
// ----------------------------------------------------------------------------
module fbms_cmp (
  input  logic                clk,
  input  fbms_pkg::cmp_ctl_t  ctl,
  input  fbms_pkg::entry_t    rd,
  output fbms_pkg::entry_t    best,
  output fbms_pkg::push_t     push
);

  logic beats;

  // strictly greater: earlier entry keeps a tie
  assign beats = rd.score > best.score;

  always_ff @(posedge clk) begin
    if (ctl.valid && (ctl.first || beats)) begin
      best <= rd;
    end
  end

  always_comb begin
    push.en   = ctl.valid && !ctl.first;
    push.data = beats ? best : rd;
  end

endmodule

/* rtl/fifo_batch_max_select.sv */
// ----------------------------------------------------------------------------
// fifo_batch_max_select
// Circular queue of tag/score entries with enqueue, best-of-batch and
// form-team commands.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command item (cmd, entry_tag, entry_score, batch_len);
//   rsp returns result items (out_tag, out_score, status, last). Every
//   command gives at least one result; last marks its final result.
//   One command is worked at a time: req.ready is high only while the
//   sequencer is idle.
// Sequence (no receiver stall):
//   enqueue, rejected or unused commands: the sequencer goes to its emit
//   step and loads the result; the next command is accepted once it is idle
//   again. A pick over k entries streams k RAM reads through the compare
//   unit, waits for the last read data, drains, then loads the result.
//   Form team runs up to TEAM_SIZE such picks one after another. The single
//   RAM read port and the shared comparator set the scan rate: one batch
//   entry per cycle.
// Reset: rst (synchronous) empties the queue, returns the sequencer to idle
//   and drops any held result. Storage contents are not cleared; only
//   occupied slots are ever read.
// Stall: a result waits in the output register while rsp.ready is low; the
//   sequencer holds in its emit step until the register is free.
// ----------------------------------------------------------------------------
module fifo_batch_max_select #(
  parameter int QUEUE_DEPTH = 64,
  parameter int TEAM_SIZE   = 5
) (
  input  logic       clk,
  input  logic       rst,
  fbms_req_if.sink   req,
  fbms_rsp_if.source rsp
);

  localparam int PW     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int TW     = $clog2(TEAM_SIZE + 1);
  localparam int BW     = fbms_pkg::BATCH_W;
  localparam int CMPW   = (CNT_W > BW) ? CNT_W : BW;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]       state;
  logic [PW-1:0]    head;
  logic [PW-1:0]    tail;
  logic [CNT_W-1:0] count;
  logic [BW-1:0]    k_reg;       // batch length of the current command
  logic [BW-1:0]    issue_left;  // batch reads still to issue
  logic             first_pend;  // next read is the first of the batch
  logic             rvalid;      // RAM read data valid this cycle
  logic             rfirst;
  logic [TW-1:0]    team_left;   // picks left including the current one
  logic [fbms_pkg::STAT_W-1:0] res_status;

  // --------------------------------------------------------------------------
  // pointer increments and batch clipping
  // --------------------------------------------------------------------------
  logic [PW-1:0] head_inc, tail_inc;
  assign head_inc = (head == PW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_inc = (tail == PW'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;

  logic            full;
  logic [BW-1:0]   k_src;
  logic [CMPW-1:0] k_w, cnt_w;
  logic [BW-1:0]   k_clip;      // min(k, count)
  logic            k_over;      // k > count

  assign full   = (count == CNT_W'(QUEUE_DEPTH));
  assign k_src  = (state == S_IDLE) ? req.batch_len : k_reg;
  assign k_w    = CMPW'(k_src);
  assign cnt_w  = CMPW'(count);
  assign k_over = k_w > cnt_w;
  assign k_clip = k_over ? BW'(cnt_w) : k_src;

  // --------------------------------------------------------------------------
  // storage and compare unit
  // --------------------------------------------------------------------------
  fbms_pkg::entry_t   rd_entry, best, enq_entry, wr_entry;
  fbms_pkg::cmp_ctl_t cmp_ctl;
  fbms_pkg::push_t    push;
  logic [$bits(fbms_pkg::entry_t)-1:0] ram_rdata;
  logic               accept, enq_wr, issue, load_out, more;

  assign accept  = req.valid && req.ready;
  assign enq_wr  = accept && (req.cmd == fbms_pkg::CMD_ENQ) && !full;
  assign issue   = (state == S_SCAN) && (issue_left != '0);

  assign enq_entry.tag   = req.entry_tag;
  assign enq_entry.score = req.entry_score;
  assign wr_entry        = push.en ? push.data : enq_entry;

  fbms_ram #(
    .WIDTH ($bits(fbms_pkg::entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (enq_wr || push.en),
    .waddr (tail),
    .wdata (wr_entry),
    .raddr (head),
    .rdata (ram_rdata)
  );

  assign rd_entry      = fbms_pkg::entry_t'(ram_rdata);
  assign cmp_ctl.valid = rvalid;
  assign cmp_ctl.first = rfirst;

  fbms_cmp u_cmp (
    .clk  (clk),
    .ctl  (cmp_ctl),
    .rd   (rd_entry),
    .best (best),
    .push (push)
  );

  // load the result when the output register is free; more: another pick of a team follows this result
  assign load_out = (state == S_EMIT) && (!rsp.valid || rsp.ready);
  assign more     = (res_status == fbms_pkg::ST_SEL) && (team_left > TW'(1)) &&
                    (count != '0);

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      rvalid     <= 1'b0;
      rfirst     <= 1'b0;
      first_pend <= 1'b0;
      issue_left <= '0;
      team_left  <= '0;
      k_reg      <= '0;
      res_status <= fbms_pkg::ST_NONE;
    end else begin
      rvalid <= issue;
      rfirst <= issue && first_pend;
      if (push.en) begin
        tail <= tail_inc;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            k_reg <= req.batch_len;
            state <= S_EMIT;
            case (req.cmd)
              fbms_pkg::CMD_ENQ: begin
                if (full) begin
                  res_status <= fbms_pkg::ST_FULL;
                end else begin
                  res_status <= fbms_pkg::ST_ENQ;
                  tail       <= tail_inc;
                  count      <= count + 1'b1;
                end
              end
              fbms_pkg::CMD_BEST: begin
                if (req.batch_len == '0 || k_over) begin
                  res_status <= fbms_pkg::ST_NONE;
                end else begin
                  res_status <= fbms_pkg::ST_SEL;
                  issue_left <= req.batch_len;
                  first_pend <= 1'b1;
                  team_left  <= TW'(1);
                  state      <= S_SCAN;
                end
              end
              fbms_pkg::CMD_TEAM: begin
                if (req.batch_len == '0 || count == '0) begin
                  res_status <= fbms_pkg::ST_NONE;
                end else begin
                  res_status <= fbms_pkg::ST_SEL;
                  issue_left <= k_clip;
                  first_pend <= 1'b1;
                  team_left  <= TW'(TEAM_SIZE);
                  state      <= S_SCAN;
                end
              end
              default: begin
                res_status <= fbms_pkg::ST_NONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (issue) begin
            head       <= head_inc;
            issue_left <= issue_left - 1'b1;
            first_pend <= 1'b0;
          end else if (!rvalid) begin
            // batch drained: best leaves the queue
            count <= count - 1'b1;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (load_out) begin
            if (more) begin
              issue_left <= k_clip;
              first_pend <= 1'b1;
              team_left  <= team_left - 1'b1;
              state      <= S_SCAN;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready = (state == S_IDLE);

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_out) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.out_tag   <= (res_status == fbms_pkg::ST_SEL) ? best.tag : '0;
      rsp.out_score <= (res_status == fbms_pkg::ST_SEL) ? best.score : '0;
      rsp.status    <= res_status;
      rsp.last      <= !more;
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  logic [PW:0]   ptr_sum;
  logic [PW-1:0] tail_exp;
  assign ptr_sum  = (PW + 1)'(head) + (PW + 1)'(count);
  assign tail_exp = (ptr_sum >= (PW + 1)'(QUEUE_DEPTH)) ?
                    PW'(ptr_sum - (PW + 1)'(QUEUE_DEPTH)) : PW'(ptr_sum);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_ptr_consistent: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (tail == tail_exp))
    else $error("tail pointer out of step with head and count");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (count != '0))
    else $error("pick running on an empty queue");

  a_non_sel_last: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != fbms_pkg::ST_SEL) |-> rsp.last)
    else $error("non-select result not marked last");

  a_reset_clears_out: assert property (@(posedge clk)
    $past(rst) |-> !rsp.valid)
    else $error("result valid right after reset");

endmodule
